// ===== sv/lru_page_replacement_core_macros.svh =====
// Assertion macros for the LRU page replacement core.
`ifndef LRU_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lpr_pkg.sv =====
// Shared constants and types of the LRU page replacement core.
`default_nettype none
package lpr_pkg;

  localparam int FRAMES    = 3;
  localparam int PAGE_BITS = 16;
  localparam int IDX_W     = 4;   // width of frame_used
  localparam int FAULT_W   = 32;  // width of fault_total
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = $clog2(FRAMES + 1);  // ranks 0..FRAMES-1, plus FRAMES for a newly loaded frame

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // Lookup token carried from cell to cell.
  typedef struct packed {
    logic                 active;
    logic [PAGE_BITS-1:0] page;
    logic                 hit;
    logic [FRAME_W-1:0]   hit_idx;
    logic [RANK_W-1:0]    hit_rank;
    logic                 empty_found;
    logic [FRAME_W-1:0]   empty_idx;
    logic [FRAME_W-1:0]   victim_idx;
  } link_t;

  // Update broadcast to all cells once the lookup resolves.
  typedef struct packed {
    logic                 en;
    logic                 load;
    logic [FRAME_W-1:0]   idx;
    logic [RANK_W-1:0]    old_rank;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

endpackage
`default_nettype wire

// ===== sv/lpr_if.sv =====
// Valid/ready channel interfaces for page references and replacement results.
`default_nettype none
interface lpr_req_if;
  logic                         valid;
  logic                         ready;
  logic [lpr_pkg::PAGE_BITS-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lpr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lpr_pkg::IDX_W-1:0]   frame_used;
  logic [lpr_pkg::FAULT_W-1:0] fault_total;

  modport source (output valid, output hit, output frame_used, output fault_total,
                  input ready);
  modport sink   (input valid, input hit, input frame_used, input fault_total,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/lru_page_replacement_core.sv =====
// LRU page replacement core: row of frame cells scanned by a lookup token.
// The token walks the cell registers one cell per cycle; result and frame update are
// registered as it leaves the last cell. A new reference waits until that lookup has
//   resolved and the result register has room.
// Reset: asynchronous, active low; clears valid bits, ranks, fault count and handshakes.
// Frame pages are not reset; they are read only behind their valid bit.
`default_nettype none
`include "lru_page_replacement_core_macros.svh"
module lru_page_replacement_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lpr_req_if.sink   req_i,
  lpr_rsp_if.source rsp_o
);

  lpr_pkg::state_e state_q, state_d;

  lpr_pkg::link_t  seed;
  lpr_pkg::link_t  chain [lpr_pkg::FRAMES];
  lpr_pkg::link_t  last;
  lpr_pkg::upd_t   upd;

  logic                        accept;
  logic                        resolve;
  logic [lpr_pkg::FRAME_W-1:0] sel_idx;
  logic [lpr_pkg::FAULT_W-1:0] fault_q, fault_d;

  logic                        rsp_valid_q;
  logic                        rsp_hit_q;
  logic [lpr_pkg::IDX_W-1:0]   rsp_frame_q;

  // Take a reference only with no lookup in flight and room in the result register
  // (a result being taken this cycle frees it).
  assign req_i.ready = (state_q == lpr_pkg::ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // Token entering cell 0: nothing found yet.
  always_comb begin
    seed        = '0;
    seed.active = accept;
    seed.page   = req_i.page;
  end

  // Cell row; each cell registers the token before handing it on.
  for (genvar g = 0; g < lpr_pkg::FRAMES; g++) begin : g_cell
    lpr_pkg::link_t link_in;
    if (g == 0) begin : g_head
      assign link_in = seed;
    end else begin : g_body
      assign link_in = chain[g-1];
    end
    lpr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (lpr_pkg::FRAME_W'(g)),
      .link_i     (link_in),
      .upd_i      (upd),
      .link_o     (chain[g])
    );
  end

  assign last    = chain[lpr_pkg::FRAMES-1];
  assign resolve = last.active;

  // Frame choice: hit frame, else lowest empty frame, else the oldest one.
  always_comb begin
    if (last.hit) begin
      sel_idx = last.hit_idx;
    end else if (last.empty_found) begin
      sel_idx = last.empty_idx;
    end else begin
      sel_idx = last.victim_idx;
    end
  end

  // Broadcast: chosen frame goes to rank 0; valid frames younger than its old
  // rank age by one. A newly loaded frame counts as older than every rank.
  always_comb begin
    upd.en       = resolve;
    upd.load     = !last.hit;
    upd.idx      = sel_idx;
    upd.old_rank = last.hit ? last.hit_rank : lpr_pkg::RANK_W'(lpr_pkg::FRAMES);
    upd.page     = last.page;
  end

  // Saturating fault counter.
  always_comb begin
    fault_d = fault_q;
    if (resolve && !last.hit && (fault_q != '1)) begin
      fault_d = fault_q + 1'b1;
    end
  end

  // Lookup sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lpr_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lpr_pkg::ST_SCAN;
        end
      end
      lpr_pkg::ST_SCAN: begin
        if (resolve) begin
          state_d = lpr_pkg::ST_IDLE;
        end
      end
      default: state_d = lpr_pkg::ST_IDLE;
    endcase
  end

  // Result register; always free at resolve since accept required it free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      fault_q     <= '0;
    end else begin
      fault_q <= fault_d;
      if (resolve) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (resolve) begin
      rsp_hit_q   <= last.hit;
      rsp_frame_q <= lpr_pkg::IDX_W'(sel_idx);
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = rsp_hit_q;
  assign rsp_o.frame_used = rsp_frame_q;
  // count moves only at resolve, which cannot happen while a result is pending
  assign rsp_o.fault_total = fault_q;

  `LPR_ASSERT(a_resolve_in_scan, !resolve || (state_q == lpr_pkg::ST_SCAN), "stray resolve")
  `LPR_ASSERT(a_rsp_free_at_resolve, !resolve || !rsp_valid_q, "result register overwritten")
  `LPR_ASSERT_NEXT(a_hit_no_fault, resolve && last.hit, fault_q == $past(fault_q), "hit counted")
  `LPR_ASSERT_NEXT(a_fault_monotone, !resolve, fault_q == $past(fault_q), "fault moved idle")

endmodule
`default_nettype wire

// ===== sv/lpr_cell.sv =====
// One frame cell: holds page, valid and rank, folds itself into the lookup token.
`default_nettype none
module lpr_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [lpr_pkg::FRAME_W-1:0] cell_idx_i,
  input  wire lpr_pkg::link_t              link_i,
  input  wire lpr_pkg::upd_t               upd_i,
  output lpr_pkg::link_t                   link_o
);

  logic [lpr_pkg::PAGE_BITS-1:0] page_q;
  logic                          valid_q;
  logic [lpr_pkg::RANK_W-1:0]    rank_q;
  lpr_pkg::link_t                link_d, link_q;

  always_comb begin
    link_d = link_i;
    if (valid_q && (page_q == link_i.page) && !link_i.hit) begin
      link_d.hit      = 1'b1;
      link_d.hit_idx  = cell_idx_i;
      link_d.hit_rank = rank_q;
    end
    if (!valid_q && !link_i.empty_found) begin
      link_d.empty_found = 1'b1;
      link_d.empty_idx   = cell_idx_i;
    end
    // with every frame valid exactly one holds the oldest rank
    if (valid_q && (rank_q == lpr_pkg::RANK_W'(lpr_pkg::FRAMES - 1))) begin
      link_d.victim_idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q  <= '0;
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      link_q <= link_d;
      if (upd_i.en) begin
        if (upd_i.idx == cell_idx_i) begin
          valid_q <= 1'b1;
          rank_q  <= '0;
        end else if (valid_q && (rank_q < upd_i.old_rank)) begin
          rank_q <= rank_q + 1'b1;
        end
      end
    end
  end

  // page store: meaningful only while valid_q is set
  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.load && (upd_i.idx == cell_idx_i)) begin
      page_q <= upd_i.page;
    end
  end

  assign link_o = link_q;

endmodule
`default_nettype wire
